// ----- hw/rtl/pli_pkg.sv -----
// Package for the piecewise linear interpolator.
// Holds opcode and status codes and the datapath widths shared by the core
// and the serial divider. No dependencies.
`default_nettype none

package pli_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int VAL_W  = 32;          // Q16.16 value width
    localparam int DIFF_W = VAL_W + 1;   // difference / magnitude width
    localparam int PROD_W = 65;          // magnitude product, below 2^64
    localparam int MAG_W  = 41;          // capped quotient, max 2^40 + 1
    localparam int SUM_W  = 43;          // y + signed magnitude before saturation

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BATCH  = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_POINT_NOT_INC = 3'd1,
        ST_TABLE_FULL    = 3'd2,
        ST_UNDER_TWO     = 3'd3,
        ST_QUERY_NOT_INC = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/pli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the breakpoint table. No dependencies.
`default_nettype none

module pli_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pli_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Divides the 65-bit product magnitude by the 32-bit segment width.
// Depends on pli_pkg.
`default_nettype none

module pli_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pli_pkg::PROD_W-1:0]  i_num,
    input  wire logic [pli_pkg::VAL_W-1:0]   i_den,
    output logic                             o_done,
    output logic      [pli_pkg::PROD_W-1:0]  o_quo,
    output logic      [pli_pkg::VAL_W-1:0]   o_rem
);

    import pli_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [PROD_W-1:0] r_quo;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_den;

    logic [VAL_W:0]    rem_sh;
    logic              ge;
    logic [VAL_W:0]    rem_diff;

    always_comb begin
        rem_sh   = {r_rem, r_quo[PROD_W-1]};
        ge       = rem_sh >= {1'b0, r_den};
        rem_diff = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_rem <= ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator, top level.
// Breakpoint table in pli_ram, sequencer and datapath here, pli_div for the
// segment division. Depends on pli_pkg, pli_ram, pli_div.
//
// Usage:
//  - A transaction is taken at a rising edge with start high and busy low.
//    Every transaction returns exactly one result: o_result_valid is high
//    for one cycle with o_result_y and o_status. The receiver cannot stall.
//  - Clear, append, start-batch and rejected queries answer in the cycle
//    after acceptance; busy stays low, so one transaction per cycle.
//  - Accepted queries raise busy. Hold-mode answers outside the table read
//    the first point (below) or the first and last points (above). An
//    interpolated query runs a binary segment search over the table RAM,
//    each probe passing S_SRCH, S_SW and S_SC, then reads both segment
//    ends and runs the one-bit-per-cycle divider. The result shows in the
//    cycle in which busy falls.
//  - i_cfg_we writes extrap_mode; write it only while idle.
//  - Reset empties the table, ends the query batch, sets extrap_mode to
//    hold. Table contents are not cleared.
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [pli_pkg::VAL_W-1:0]  i_point_x,
    input  wire logic [pli_pkg::VAL_W-1:0]  i_point_y,
    input  wire logic [pli_pkg::VAL_W-1:0]  i_query_x,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_wdata,
    output logic                            o_result_valid,
    output logic      [pli_pkg::VAL_W-1:0]  o_result_y,
    output logic      [2:0]                 o_status
);

    import pli_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] Y_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] Y_MIN   = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_X0_W, S_X0, S_XL_W, S_XL, S_SRCH, S_SW, S_SC,
        S_FA_W, S_FA, S_FB_W, S_FB, S_MAG, S_MUL, S_DIVST, S_DIV, S_FIN
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [VAL_W-1:0]      r_last_x;
    logic [VAL_W-1:0]      r_prev_q;
    logic                  r_seen;
    logic                  r_mode;
    logic [VAL_W-1:0]      r_q;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W-1:0]     r_lo;
    logic [ADDR_W-1:0]     r_hi;
    logic [VAL_W-1:0]      r_xa;
    logic [VAL_W-1:0]      r_ya;
    logic [DIFF_W-1:0]     r_dy;
    logic [DIFF_W-1:0]     r_dq;
    logic [VAL_W-1:0]      r_den;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_prod;
    logic [MAG_W-1:0]      r_mag;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_y;
    t_status               r_out_status;

    logic                  acc;
    logic                  append_ok;
    logic                  query_go;
    t_status               idle_status;
    logic [2*VAL_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]      rd_x;
    logic [VAL_W-1:0]      rd_y;
    logic                  q_le_rd;
    logic [CNT_W-1:0]      cnt_m1;
    logic [ADDR_W-1:0]     last_addr;
    logic [ADDR_W:0]       mid_sum;
    logic [ADDR_W-1:0]     mid;
    logic [2*DIFF_W-1:0]   prod_full;
    logic                  div_start;
    logic                  div_done;
    logic [PROD_W-1:0]     div_quo;
    logic [VAL_W-1:0]      div_rem;
    logic                  quo_cap;
    logic                  round_up;
    logic [MAG_W-1:0]      n_mag;
    logic [SUM_W-1:0]      ya_ext;
    logic [SUM_W-1:0]      mag_ext;
    logic [SUM_W-1:0]      sum;
    logic [VAL_W-1:0]      n_sat;

    always_comb begin
        acc         = start && (r_state == S_IDLE);
        append_ok   = 1'b0;
        query_go    = 1'b0;
        idle_status = ST_OK;
        case (i_opcode)
            OP_APPEND: begin
                if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    idle_status = ST_TABLE_FULL;
                end else if ((r_count != '0) &&
                             ($signed(i_point_x) <= $signed(r_last_x))) begin
                    idle_status = ST_POINT_NOT_INC;
                end else begin
                    append_ok = 1'b1;
                end
            end
            OP_QUERY: begin
                if (r_count < CNT_W'(2)) begin
                    idle_status = ST_UNDER_TWO;
                end else if (r_seen && ($signed(i_query_x) <= $signed(r_prev_q))) begin
                    idle_status = ST_QUERY_NOT_INC;
                end else begin
                    query_go = 1'b1;
                end
            end
            default: begin
                idle_status = ST_OK;
            end
        endcase

        rd_x      = ram_rdata[2*VAL_W-1:VAL_W];
        rd_y      = ram_rdata[VAL_W-1:0];
        q_le_rd   = $signed(r_q) <= $signed(rd_x);
        cnt_m1    = r_count - CNT_W'(1);
        last_addr = cnt_m1[ADDR_W-1:0];
        mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
        mid       = mid_sum[ADDR_W:1];
        prod_full = r_dy * r_dq;
        div_start = (r_state == S_DIVST);

        quo_cap  = (|div_quo[PROD_W-1:MAG_W]) ||
                   (div_quo[MAG_W-1] && (|div_quo[MAG_W-2:0]));
        round_up = {div_rem, 1'b0} >= {1'b0, r_den};
        n_mag    = quo_cap ? MAG_CAP
                           : div_quo[MAG_W-1:0] + MAG_W'(round_up);

        ya_ext  = {{(SUM_W-VAL_W){r_ya[VAL_W-1]}}, r_ya};
        mag_ext = {{(SUM_W-MAG_W){1'b0}}, r_mag};
        sum     = r_neg ? ya_ext - mag_ext : ya_ext + mag_ext;
        if ((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1])) begin
            n_sat = sum[VAL_W-1:0];
        end else begin
            n_sat = sum[SUM_W-1] ? Y_MIN : Y_MAX;
        end
    end

    pli_ram #(
        .WIDTH  (2*VAL_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (acc && append_ok),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_prev_q    <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_q <= i_query_x;
                        if (query_go) begin
                            r_prev_q <= i_query_x;
                            r_seen   <= 1'b1;
                            r_addr   <= '0;
                            r_state  <= S_X0_W;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_y      <= '0;
                            r_out_status <= idle_status;
                        end
                        if (i_opcode == OP_CLEAR) begin
                            r_count <= '0;
                            r_seen  <= 1'b0;
                        end
                        if (i_opcode == OP_BATCH) begin
                            r_seen <= 1'b0;
                        end
                        if (append_ok) begin
                            r_count  <= r_count + CNT_W'(1);
                            r_last_x <= i_point_x;
                        end
                    end
                end
                S_X0_W: begin
                    r_state <= S_X0;
                end
                S_X0: begin
                    if (q_le_rd) begin
                        if (!r_mode) begin
                            r_out_valid  <= 1'b1;
                            r_out_y      <= rd_y;
                            r_out_status <= ST_OK;
                            r_state      <= S_IDLE;
                        end else begin
                            r_lo    <= ADDR_W'(1);
                            r_hi    <= ADDR_W'(1);
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_addr  <= last_addr;
                        r_state <= S_XL_W;
                    end
                end
                S_XL_W: begin
                    r_state <= S_XL;
                end
                S_XL: begin
                    if (!q_le_rd) begin
                        if (!r_mode) begin
                            r_out_valid  <= 1'b1;
                            r_out_y      <= rd_y;
                            r_out_status <= ST_OK;
                            r_state      <= S_IDLE;
                        end else begin
                            r_lo    <= last_addr;
                            r_hi    <= last_addr;
                            r_state <= S_SRCH;
                        end
                    end else begin
                        r_lo    <= ADDR_W'(1);
                        r_hi    <= last_addr;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo == r_hi) begin
                        r_addr  <= r_lo - ADDR_W'(1);
                        r_state <= S_FA_W;
                    end else begin
                        r_addr  <= mid;
                        r_state <= S_SW;
                    end
                end
                S_SW: begin
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (q_le_rd) begin
                        r_hi <= r_addr;
                    end else begin
                        r_lo <= r_addr + ADDR_W'(1);
                    end
                    r_state <= S_SRCH;
                end
                S_FA_W: begin
                    r_state <= S_FA;
                end
                S_FA: begin
                    r_xa    <= rd_x;
                    r_ya    <= rd_y;
                    r_addr  <= r_lo;
                    r_state <= S_FB_W;
                end
                S_FB_W: begin
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_dy    <= {rd_y[VAL_W-1], rd_y} - {r_ya[VAL_W-1], r_ya};
                    r_dq    <= {r_q[VAL_W-1], r_q} - {r_xa[VAL_W-1], r_xa};
                    r_den   <= rd_x - r_xa;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_neg   <= r_dy[DIFF_W-1] ^ r_dq[DIFF_W-1];
                    r_dy    <= r_dy[DIFF_W-1] ? -r_dy : r_dy;
                    r_dq    <= r_dq[DIFF_W-1] ? -r_dq : r_dq;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod_full[PROD_W-1:0];
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_mag   <= n_mag;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out_valid  <= 1'b1;
                    r_out_y      <= n_sat;
                    r_out_status <= ST_OK;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result_y     = r_out_y;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

// ----- hw/rtl/pli_checker.sv -----
// Port-level checks for the piecewise linear interpolator, bound to the top.
// Depends on pli_pkg and piecewise_linear_interpolator.
`default_nettype none

module pli_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_result_valid,
    input wire logic [pli_pkg::VAL_W-1:0] o_result_y,
    input wire logic [2:0]                o_status
);

    import pli_pkg::*;

    // every accepted transaction either answers next cycle or goes busy
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("accepted transaction neither answered nor started work");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("query finished without a result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a transaction");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_OK)) |-> (o_result_y == '0))
        else $error("error result carries a nonzero value");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result_y     (o_result_y),
    .o_status       (o_status)
);

`default_nettype wire

// ----- test/piecewise_linear_interpolator_tb.sv -----
// Testbench for piecewise_linear_interpolator: queued transactions go through a start/busy
// driver, a bit-exact interpolation predictor and a result monitor with a stall watchdog.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL.
`default_nettype none

module piecewise_linear_interpolator_tb;
    import pli_pkg::*;

    localparam int     DEPTH     = TABLE_DEPTH_DEF;
    localparam int     STALL_MAX = 3000;
    localparam int     CHUNK_LEN = 125;
    localparam longint INT_MAX_L = 64'sd2147483647;
    localparam longint INT_MIN_L = -64'sd2147483648;
    localparam longint MAG_CAP   = longint'(1) << 40;
    localparam logic [31:0] V_MIN = 32'h8000_0000;
    localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] qx;
    } pli_cmd_t;

    typedef struct packed {
        logic [31:0] y;
        t_status     st;
    } pli_answer_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_opcode = '0;
    logic [31:0] i_point_x = '0;
    logic [31:0] i_point_y = '0;
    logic [31:0] i_query_x = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        busy;
    logic        o_result_valid;
    logic [31:0] o_result_y;
    logic [2:0]  o_status;

    pli_cmd_t    cmd_queue[$];
    pli_answer_t expected_answers[$];
    int          idle_pct = 0;
    int          chunk_items = 0;
    int          mismatch_count = 0;
    int          result_index = 0;
    int          stall_cycles = 0;

    // predictor state
    longint      table_x[DEPTH];
    longint      table_y[DEPTH];
    int          table_len = 0;
    longint      last_query = 0;
    bit          batch_open = 1'b0;
    bit          extend_ends = 1'b0;

    piecewise_linear_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_query_x      (i_query_x),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result_y     (o_result_y),
        .o_status       (o_status)
    );

    always #10 i_clk = ~i_clk;

    // ya + round((yb-ya)*(q-xa)/(xb-xa)), ties away from zero, magnitude capped, saturated
    function automatic logic [31:0] interp_segment(longint xa, longint ya, longint xb,
                                                   longint yb, longint q);
        longint       dy, dq, mag, r;
        logic [127:0] prod, quo, rem, den;
        dy = yb - ya;
        dq = q - xa;
        den = 128'(xb - xa);
        prod = 128'(dy < 0 ? -dy : dy) * 128'(dq < 0 ? -dq : dq);
        quo = prod / den;
        rem = prod % den;
        if (quo > 128'(MAG_CAP)) begin
            mag = MAG_CAP;
        end else begin
            mag = longint'(quo[63:0]) + (((rem << 1) >= den) ? 1 : 0);
        end
        r = ((dy < 0) != (dq < 0)) ? ya - mag : ya + mag;
        if (r > INT_MAX_L) r = INT_MAX_L;
        if (r < INT_MIN_L) r = INT_MIN_L;
        return 32'(r);
    endfunction

    function automatic pli_answer_t predict_answer(pli_cmd_t c);
        pli_answer_t ans;
        longint      q;
        int          n, j;
        ans.y = '0;
        ans.st = ST_OK;
        q = longint'($signed(c.qx));
        n = table_len;
        case (c.op)
            OP_CLEAR: begin
                table_len = 0;
                batch_open = 1'b0;
            end
            OP_APPEND: begin
                if (table_len >= DEPTH) begin
                    ans.st = ST_TABLE_FULL;
                end else if (table_len > 0 &&
                             longint'($signed(c.px)) <= table_x[table_len-1]) begin
                    ans.st = ST_POINT_NOT_INC;
                end else begin
                    table_x[table_len] = longint'($signed(c.px));
                    table_y[table_len] = longint'($signed(c.py));
                    table_len++;
                end
            end
            OP_BATCH: begin
                batch_open = 1'b0;
            end
            default: begin
                if (n < 2) begin
                    ans.st = ST_UNDER_TWO;
                end else if (batch_open && q <= last_query) begin
                    ans.st = ST_QUERY_NOT_INC;
                end else begin
                    if (q <= table_x[0]) begin
                        ans.y = extend_ends ? interp_segment(table_x[0], table_y[0],
                                                             table_x[1], table_y[1], q)
                                            : 32'(table_y[0]);
                    end else if (q > table_x[n-1]) begin
                        ans.y = extend_ends ? interp_segment(table_x[n-2], table_y[n-2],
                                                             table_x[n-1], table_y[n-1], q)
                                            : 32'(table_y[n-1]);
                    end else begin
                        j = 1;
                        while (j < n - 1 && q > table_x[j]) j++;
                        ans.y = interp_segment(table_x[j-1], table_y[j-1],
                                               table_x[j], table_y[j], q);
                    end
                    last_query = q;
                    batch_open = 1'b1;
                end
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR: result %0d %s: got %h, want %h", result_index, what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        pli_cmd_t c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                c.op = t_opcode'(i_opcode);
                c.px = i_point_x;
                c.py = i_point_y;
                c.qx = i_query_x;
                expected_answers.push_back(predict_answer(c));
            end
            if (!(start && busy)) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    c = cmd_queue.pop_front();
                    start <= 1'b1;
                    i_opcode <= c.op;
                    i_point_x <= c.px;
                    i_point_y <= c.py;
                    i_query_x <= c.qx;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        pli_answer_t e;
        if (i_rst_n && o_result_valid) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("with no transaction outstanding", o_result_y, '0);
            end else begin
                e = expected_answers.pop_front();
                if (o_result_y !== e.y) report_mismatch("result_y", o_result_y, e.y);
                if (o_status !== e.st) report_mismatch("status", 32'(o_status), 32'(e.st));
            end
            result_index++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint rand_between(longint lo, longint hi);
        logic [63:0] rnd;
        rnd = {$urandom(), $urandom()};
        return lo + longint'(rnd % 64'(hi - lo + 1));
    endfunction

    function automatic longint rand_level();
        case ($urandom_range(3))
            0, 1: return longint'($signed($urandom()));
            2: return rand_between(-(1 << 20), 1 << 20);
            default: return $urandom_range(1) ? INT_MAX_L : INT_MIN_L;
        endcase
    endfunction

    task automatic push_cmd(t_opcode op, logic [31:0] px, logic [31:0] py, logic [31:0] qx);
        pli_cmd_t c;
        c.op = op;
        c.px = px;
        c.py = py;
        c.qx = qx;
        cmd_queue.push_back(c);
        chunk_items++;
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || start || expected_answers.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_extension(bit v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        extend_ends = v;
        @(negedge i_clk);
    endtask

    // mostly: clear, load an increasing table, open a batch, run increasing queries
    task automatic load_and_query();
        longint xs[$];
        longint x, bad, step_cap, lo, hi, q, qcap, span;
        int     npts, nq, k, r;
        bit     found;
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 4))
                push_cmd(t_opcode'($urandom_range(3)), $urandom(), $urandom(), $urandom());
            return;
        end
        if ($urandom_range(99) < 92) push_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom());
        r = $urandom_range(99);
        npts = (r < 8) ? $urandom_range(1) : (r < 85) ? $urandom_range(2, 8)
                                                      : $urandom_range(9, 40);
        case ($urandom_range(3))
            0: step_cap = 4;
            1: step_cap = longint'(1) << 16;
            2: step_cap = longint'(1) << 24;
            default: step_cap = (longint'(1) << 32) / (npts + 1);
        endcase
        hi = INT_MAX_L - npts * step_cap;
        if (hi < INT_MIN_L) hi = INT_MIN_L;
        x = rand_between(INT_MIN_L, hi);
        for (k = 0; k < npts; k++) begin
            if (k > 0) x += rand_between(1, step_cap);
            if (x > INT_MAX_L) break;
            if (k > 0 && $urandom_range(99) < 3) begin
                bad = xs[$] - rand_between(0, step_cap);
                if (bad < INT_MIN_L) bad = INT_MIN_L;
                push_cmd(OP_APPEND, 32'(bad), 32'(rand_level()), $urandom());
            end
            push_cmd(OP_APPEND, 32'(x), 32'(rand_level()), $urandom());
            xs.push_back(x);
        end
        if ($urandom_range(99) < 95) push_cmd(OP_BATCH, $urandom(), $urandom(), $urandom());
        if (xs.size() == 0) begin
            lo = INT_MIN_L;
            hi = INT_MAX_L;
        end else begin
            span = xs[$] - xs[0];
            lo = xs[0] - span / 4 - 2;
            hi = xs[$] + span / 4 + 2;
            if (lo < INT_MIN_L) lo = INT_MIN_L;
            if (hi > INT_MAX_L) hi = INT_MAX_L;
        end
        nq = $urandom_range(1, 10);
        qcap = (hi - lo) / nq * 2 + 1;
        q = lo + rand_between(0, qcap / 2);
        if (q > INT_MAX_L) q = INT_MAX_L;
        for (k = 0; k < nq; k++) begin
            if ($urandom_range(99) < 4) begin
                push_cmd(OP_QUERY, $urandom(), $urandom(), $urandom());
            end else begin
                push_cmd(OP_QUERY, $urandom(), $urandom(), 32'(q));
            end
            found = 1'b0;
            if ($urandom_range(3) == 0) begin
                foreach (xs[i]) begin
                    if (!found && xs[i] > q) begin
                        q = xs[i];
                        found = 1'b1;
                    end
                end
            end
            if (!found) q += rand_between(1, qcap);
            if (q > INT_MAX_L) break;
        end
    endtask

    // table filled to depth, then appends past full, then queries over it
    task automatic fill_table();
        longint x0, step, q;
        int     k;
        push_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom());
        step = rand_between(1, 1 << 20);
        x0 = rand_between(INT_MIN_L, INT_MAX_L - 300 * step);
        for (k = 0; k < DEPTH; k++)
            push_cmd(OP_APPEND, 32'(x0 + k * step), 32'(rand_level()), $urandom());
        push_cmd(OP_APPEND, 32'(x0 + 300 * step), 32'(rand_level()), $urandom());
        push_cmd(OP_APPEND, 32'(x0), 32'(rand_level()), $urandom());
        push_cmd(OP_BATCH, $urandom(), $urandom(), $urandom());
        q = x0 - step;
        for (k = 0; k < 12; k++) begin
            push_cmd(OP_QUERY, $urandom(), $urandom(), 32'(q));
            q += rand_between(1, 24 * step);
        end
    endtask

    initial begin
        int chunk;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 36;
        write_extension(1'b0);

        // hold mode: empty and one-point tables, an equal append, a repeated query, extremes
        push_cmd(OP_QUERY, '0, '0, '0);
        push_cmd(OP_APPEND, V_MIN, V_MAX, '0);
        push_cmd(OP_QUERY, '0, '0, V_MAX);
        push_cmd(OP_APPEND, V_MIN, '0, '0);
        push_cmd(OP_APPEND, '0, V_MIN, '0);
        push_cmd(OP_APPEND, V_MAX, 32'hFFFF_FFFF, '0);
        push_cmd(OP_BATCH, '0, '0, '0);
        push_cmd(OP_QUERY, '0, '0, V_MIN);
        push_cmd(OP_QUERY, '0, '0, 32'hFFFF_FFFF);
        push_cmd(OP_QUERY, '0, '0, 32'hFFFF_FFFF);
        push_cmd(OP_QUERY, '0, '0, V_MAX);
        // rounding ties in both directions, hold above the table
        push_cmd(OP_CLEAR, '0, '0, '0);
        push_cmd(OP_APPEND, 32'd0, 32'd0, '0);
        push_cmd(OP_APPEND, 32'd2, 32'd1, '0);
        push_cmd(OP_APPEND, 32'd4, 32'd0, '0);
        push_cmd(OP_QUERY, '0, '0, 32'd1);
        push_cmd(OP_QUERY, '0, '0, 32'd3);
        push_cmd(OP_QUERY, '0, '0, 32'd5);
        wait_drained();

        // linear extension both ways, query at the first point, saturation
        write_extension(1'b1);
        push_cmd(OP_BATCH, '0, '0, '0);
        push_cmd(OP_QUERY, '0, '0, V_MIN);
        push_cmd(OP_QUERY, '0, '0, 32'd0);
        push_cmd(OP_QUERY, '0, '0, 32'd6);
        push_cmd(OP_CLEAR, '0, '0, '0);
        push_cmd(OP_APPEND, 32'd0, 32'd0, '0);
        push_cmd(OP_APPEND, 32'd1, V_MAX, '0);
        push_cmd(OP_QUERY, '0, '0, V_MIN);
        push_cmd(OP_QUERY, '0, '0, V_MAX);
        wait_drained();

        for (chunk = 0; chunk < 6; chunk++) begin
            idle_pct = (chunk < 2) ? 36 : (chunk < 4) ? 78 : 0;
            write_extension(chunk % 2);
            chunk_items = 0;
            if (chunk == 4) fill_table();
            while (chunk_items < CHUNK_LEN) begin
                load_and_query();
                if ($urandom_range(99) < 4) wait_drained();
            end
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
